>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the volume fade ramp.
// Each macro checks on the rising edge of aclk and is off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/vfr_pkg.sv
// Package for the volume fade ramp: opcodes, register indexes and fixed widths.
// No dependencies.
`default_nettype none

package vfr_pkg;

    localparam int OP_W      = 2;
    localparam int VOL_IN_W  = 8;
    localparam int MS_W      = 16;
    localparam int CFG_IDX_W = 1;

    typedef logic [OP_W-1:0] opcode_t;

    localparam opcode_t OP_TICK      = 2'd0;
    localparam opcode_t OP_FADE_REQ  = 2'd1;
    localparam opcode_t OP_RETARGET  = 2'd2;
    localparam opcode_t OP_WRITE_MAIN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FADE_DURATION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL  = 1'd1;

    localparam logic [MS_W-1:0] FADE_DURATION_RESET = 16'd2000;
    localparam logic [MS_W-1:0] MIN_INTERVAL_RESET  = 16'd10;
    localparam logic [MS_W-1:0] MS_MAX              = 16'hFFFF;

    // Result fields, packed from the top down: amp_write is bit 0, fading the highest bit.
    typedef struct packed {
        logic                fading;
        logic                step_up;
        logic                fade_done;
        logic [VOL_IN_W-1:0] amp_volume;
        logic                amp_write;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/volume_fade_ramp.sv
// Volume fade ramp, a master-volume fader stepped by millisecond ticks.
// Depends on vfr_pkg and assert_macros.svh.
// Ticks, retargets and main-volume writes give their result straight from the idle
// state, and so do fade requests that repeat the last request or set the volume at
// once. A fade request that starts a ramp toward a different volume runs the
// shift-subtract divider, which works out duration / distance one quotient bit per
// cycle, then a finish state. A request whose target equals the main volume skips
// the divider for the finish state. Each input transfer gives exactly one result
// transfer, and a result that waits on m_tready holds off the next input transfer.
`default_nettype none

`include "assert_macros.svh"

module volume_fade_ramp
    import vfr_pkg::*;
#(
    parameter int VOLUME_BITS = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input channel.
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] volume_value
    input  wire logic [OP_W-1:0]      s_tuser,   // [1:0] opcode
    // Result channel.
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // [0] amp_write, [8:1] amp_volume, [9] fade_done, [10] step_up, [11] fading
    output      logic [15:0]          m_tdata,
    // Configuration write port.
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MS_W-1:0]      cfg_wdata
);

    localparam int VB      = VOLUME_BITS;
    localparam int CNT_W   = $clog2(MS_W);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MS_W - 1);

    logic [1:0]      state_reg, state_next;
    logic [MS_W-1:0] duration_reg, min_ivl_reg;
    logic [VB-1:0]   current_reg, current_next;
    logic [VB-1:0]   target_reg, target_next;
    logic            ramp_up_reg, ramp_up_next;
    logic [MS_W-1:0] interval_reg, interval_next;
    logic [MS_W-1:0] elapsed_reg, elapsed_next;
    logic [VB-1:0]   main_reg, main_next;
    logic [VB-1:0]   last_req_reg, last_req_next;

    // Divider: remainder, dividend shifting into quotient, divisor, step count.
    logic [VB-1:0]    rem_reg, rem_next;
    logic [MS_W-1:0]  quo_reg, quo_next;
    logic [VB-1:0]    dist_reg, dist_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic    m_valid_reg, m_valid_next;
    result_t m_data_reg, m_data_next;

    logic            in_xfer;
    opcode_t         op;
    logic [VB-1:0]   vin;
    logic [VB:0]     rem_sh;
    logic            rem_ge;
    logic [MS_W-1:0] elapsed_inc;
    logic [VB:0]     up_next;
    logic [VB-1:0]   down_next;
    logic            reached;
    logic [VB-1:0]   step_vol;
    logic [MS_W-1:0] min_eff;
    logic [MS_W-1:0] quo_ivl;

    assign op       = s_tuser;
    assign vin      = VB'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign in_xfer  = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 16'(m_data_reg);

    // Divider step.
    assign rem_sh = {rem_reg, quo_reg[MS_W-1]};
    assign rem_ge = rem_sh >= {1'b0, dist_reg};

    // Tick arithmetic.
    assign elapsed_inc = (elapsed_reg != MS_MAX) ? elapsed_reg + 16'd1 : elapsed_reg;
    assign up_next     = {1'b0, current_reg} + {{VB{1'b0}}, 1'b1};
    assign down_next   = current_reg - {{(VB-1){1'b0}}, 1'b1};

    always_comb begin
        if (current_reg == target_reg) begin
            reached = 1'b1;
        end else if (ramp_up_reg) begin
            reached = up_next >= {1'b0, target_reg};
        end else begin
            // Stepping below zero also ends the fade.
            reached = (current_reg == '0) || (down_next <= target_reg);
        end
        if (reached) begin
            step_vol = target_reg;
        end else if (ramp_up_reg) begin
            step_vol = up_next[VB-1:0];
        end else begin
            step_vol = down_next;
        end
    end

    assign min_eff = (min_ivl_reg == '0) ? 16'd1 : min_ivl_reg;
    // A zero distance skips the divider and leaves the full duration in quo_reg.
    assign quo_ivl = (quo_reg < min_eff) ? min_eff : quo_reg;

    always_comb begin
        state_next    = state_reg;
        current_next  = current_reg;
        target_next   = target_reg;
        ramp_up_next  = ramp_up_reg;
        interval_next = interval_reg;
        elapsed_next  = elapsed_reg;
        main_next     = main_reg;
        last_req_next = last_req_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dist_next     = dist_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    m_data_next            = '0;
                    m_data_next.step_up    = ramp_up_reg;
                    m_data_next.fading     = interval_reg != '0;
                    m_valid_next           = 1'b1;
                    unique case (op)
                        OP_TICK: begin
                            if (interval_reg != '0) begin
                                elapsed_next = elapsed_inc;
                                if (elapsed_inc >= interval_reg) begin
                                    elapsed_next          = '0;
                                    current_next          = step_vol;
                                    m_data_next.amp_write = 1'b1;
                                    m_data_next.amp_volume = VOL_IN_W'(step_vol);
                                    if (reached) begin
                                        main_next             = target_reg;
                                        interval_next         = '0;
                                        m_data_next.fade_done = 1'b1;
                                        m_data_next.fading    = 1'b0;
                                    end
                                end
                            end
                        end
                        OP_FADE_REQ: begin
                            if (vin != last_req_reg) begin
                                last_req_next = vin;
                                if (duration_reg == '0) begin
                                    m_data_next.amp_write  = 1'b1;
                                    m_data_next.amp_volume = VOL_IN_W'(vin);
                                end else begin
                                    // The result leaves once the interval is known.
                                    m_valid_next = 1'b0;
                                    current_next = main_reg;
                                    target_next  = vin;
                                    ramp_up_next = vin > main_reg;
                                    dist_next    = (vin > main_reg) ? vin - main_reg
                                                                    : main_reg - vin;
                                    rem_next     = '0;
                                    quo_next     = duration_reg;
                                    cnt_next     = '0;
                                    state_next   = (vin == main_reg) ? ST_FINISH : ST_DIV;
                                end
                            end
                        end
                        OP_RETARGET: begin
                            if (interval_reg != '0) begin
                                target_next = main_reg;
                            end
                        end
                        default: begin
                            main_next = vin;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                rem_next = rem_ge ? VB'(rem_sh - {1'b0, dist_reg}) : rem_sh[VB-1:0];
                quo_next = {quo_reg[MS_W-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                interval_next       = quo_ivl;
                elapsed_next        = '0;
                m_data_next         = '0;
                m_data_next.step_up = ramp_up_reg;
                m_data_next.fading  = 1'b1;
                m_valid_next        = 1'b1;
                state_next          = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            duration_reg <= FADE_DURATION_RESET;
            min_ivl_reg  <= MIN_INTERVAL_RESET;
            current_reg  <= '0;
            target_reg   <= '0;
            ramp_up_reg  <= 1'b0;
            interval_reg <= '0;
            elapsed_reg  <= '0;
            main_reg     <= '0;
            last_req_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            current_reg  <= current_next;
            target_reg   <= target_next;
            ramp_up_reg  <= ramp_up_next;
            interval_reg <= interval_next;
            elapsed_reg  <= elapsed_next;
            main_reg     <= main_next;
            last_req_reg <= last_req_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_FADE_DURATION: duration_reg <= cfg_wdata;
                    REG_MIN_INTERVAL:  min_ivl_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dist_reg   <= dist_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
    end

    `ASSERT_SAME(a_elapsed_below_interval,
        (state_reg == ST_IDLE) && (interval_reg != '0), elapsed_reg < interval_reg,
        "elapsed count reached the step interval without a step")
    `ASSERT_SAME(a_done_writes_amp, m_valid_reg && m_data_reg.fade_done,
        m_data_reg.amp_write, "fade completion without an amplifier write")
    `ASSERT_NEXT(a_div_progress, state_reg == ST_DIV,
        (state_reg == ST_DIV) || (state_reg == ST_FINISH), "divider left its sequence")
    `ASSERT_SAME(a_slot_free_in_div, state_reg == ST_DIV, !m_valid_reg,
        "result pending while the divider runs")

endmodule

`default_nettype wire
